### rtl/mmd_pkg.sv
`default_nettype none
package mmd_pkg;

   localparam int MAX_LEN     = 1024;
   localparam int ADDR_BITS   = 10;
   localparam int LEN_BITS    = 11;
   localparam int SAMPLE_BITS = 16;
   localparam int VAL_BITS    = SAMPLE_BITS + 1;
   localparam int PROD_BITS   = 33;

   localparam int NARROW_SPAN = 9;
   localparam int WIDE_SPAN   = 25;
   localparam int SPAN_BITS   = 5;

   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GAIN = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WIDE = 2'd1;

   localparam logic [15:0] GAIN_RESET = 16'd1738;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   localparam logic KIND_SUMMARY = 1'b0;
   localparam logic KIND_SAMPLE  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_WIN,
      ST_MED,
      ST_DEV,
      ST_MAD,
      ST_STORE,
      ST_SEL,
      ST_SUM,
      ST_MUL,
      ST_CLEAN,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

### rtl/median_mad_despiker.sv
`default_nettype none
// Median/MAD spike filter. Load a series with func=0 transactions, one per cycle when
// req_stall is low; the transaction carrying last_in closes the series (up to 1024
// samples, extras dropped) and starts processing, which ends with one summary transaction
// (kind=0, spike_count). Each func=1 transaction then returns the next cleaned sample
// through a registered sample memory read. Processing with a window span of 9 or 25 runs
// local statistics for each sample (window fetch, rank select of the median, rank
// select of the MAD), then a radix select, one pass per bit, for the median of the
// MADs, then a cleaning pass; series under 9 samples go straight to the cleaning pass.
// No transaction is taken while processing. Configuration writes belong to idle time.
module median_mad_despiker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_stall,
   input  wire logic                                 req_func,
   input  wire logic signed [mmd_pkg::SAMPLE_BITS-1:0] req_sample,
   input  wire logic                                 req_last_in,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   output      logic                                 rsp_kind,
   output      logic signed [mmd_pkg::SAMPLE_BITS-1:0] rsp_cleaned,
   output      logic                                 rsp_was_spike,
   output      logic [mmd_pkg::LEN_BITS-1:0]         rsp_spike_count,
   output      logic                                 rsp_last_out,
   input  wire logic                                 csr_we,
   input  wire logic [mmd_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  wire logic [15:0]                          csr_wdata
);

   localparam int AB = mmd_pkg::ADDR_BITS;
   localparam int LB = mmd_pkg::LEN_BITS;
   localparam int SB = mmd_pkg::SAMPLE_BITS;
   localparam int VB = mmd_pkg::VAL_BITS;
   localparam int WS = mmd_pkg::WIDE_SPAN;
   localparam int PB = mmd_pkg::SPAN_BITS;

   // memories: sample word is {spike mark, sample}
   logic [SB:0]   samp_mem [mmd_pkg::MAX_LEN];
   logic [SB-1:0] med_mem  [mmd_pkg::MAX_LEN];
   logic [SB-1:0] mad_mem  [mmd_pkg::MAX_LEN];

   logic [SB:0]   samp_rdata_ff;
   logic [SB-1:0] med_rdata_ff, mad_rdata_ff;
   logic          samp_we, stat_we;
   logic [AB-1:0] samp_waddr, samp_raddr, stat_raddr;
   logic [SB:0]   samp_wdata;

   mmd_pkg::state_type state_ff, state_in;

   logic [15:0]   gain_ff, gain_in;
   logic          wide_ff, wide_in;
   logic [LB-1:0] len_ff, len_in, rp_ff, rp_in, spikes_ff, spikes_in;
   logic          proc_ff, proc_in;
   logic [AB-1:0] pos_ff, pos_in, widx_ff, widx_in;
   logic [PB-1:0] k_ff, k_in;
   logic [LB-1:0] i_ff, i_in;
   logic          dv_ff, dv_in;
   logic [3:0]    bit_ff, bit_in;
   logic [SB-1:0] pa_ff, pa_in, pb_ff, pb_in;
   logic [LB-1:0] ka_ff, ka_in, kb_ff, kb_in, cnta_ff, cnta_in, cntb_ff, cntb_in;
   logic [SB:0]   twice_ff, twice_in;
   logic [mmd_pkg::PROD_BITS-1:0] prod_ff, prod_in;
   logic          ok_ff, ok_in;
   logic signed [VB-1:0] med_ff, med_in, sel_ff, sel_in;
   logic signed [VB-1:0] val_ff [WS];
   logic signed [VB-1:0] val_in [WS];

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_kind_ff, rsp_kind_in;
   logic [SB-1:0] rsp_cleaned_ff, rsp_cleaned_in;
   logic          rsp_spike_ff, rsp_spike_in;
   logic [LB-1:0] rsp_count_ff, rsp_count_in;
   logic          rsp_last_ff, rsp_last_in;

   // window geometry
   logic [PB-1:0] span_w, half_w;
   logic [LB-1:0] start_w, pos_ext, half_ext, span_ext;

   // rank select over the window
   logic signed [VB-1:0] cand;
   logic [WS-1:0]        below;
   logic [PB-1:0]        rank;
   logic signed [VB:0]   dif [WS];

   // median-of-MAD radix select and cleaning datapath
   logic [SB:0]          mask_sh;
   logic [SB-1:0]        hi_mask;
   logic signed [VB-1:0] cl_dif;
   logic [SB-1:0]        cl_abs;
   logic                 cl_spike;
   logic                 accept;
   logic [LB-1:0]        eff_len;

   assign span_w   = (wide_ff && len_ff >= LB'(mmd_pkg::WIDE_SPAN))
                     ? PB'(mmd_pkg::WIDE_SPAN) : PB'(mmd_pkg::NARROW_SPAN);
   assign half_w   = span_w >> 1;
   assign pos_ext  = {1'b0, pos_ff};
   assign half_ext = LB'(half_w);
   assign span_ext = LB'(span_w);

   always_comb begin
      if (pos_ext < half_ext) begin
         start_w = '0;
      end else if (pos_ext - half_ext + span_ext > len_ff) begin
         start_w = len_ff - span_ext;
      end else begin
         start_w = pos_ext - half_ext;
      end
   end

   always_comb begin
      cand = val_ff[k_ff];
      for (int j = 0; j < WS; j++) begin
         below[j] = (PB'(j) < span_w) &&
                    ((val_ff[j] < cand) || (val_ff[j] == cand && PB'(j) < k_ff));
         dif[j]   = (VB+1)'(val_ff[j]) - (VB+1)'(sel_ff);
      end
      rank = PB'($countones(below));
   end

   assign mask_sh = {(SB+1){1'b1}} << ({1'b0, bit_ff} + 5'd1);
   assign hi_mask = mask_sh[SB-1:0];

   always_comb begin
      cl_dif   = VB'(signed'(samp_rdata_ff[SB-1:0])) - VB'(signed'(med_rdata_ff));
      cl_abs   = cl_dif[VB-1] ? SB'(-cl_dif) : cl_dif[SB-1:0];
      cl_spike = ok_ff &&
                 (mmd_pkg::PROD_BITS'({cl_abs, 9'd0}) > prod_ff);
   end

   assign req_stall = (state_ff != mmd_pkg::ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign eff_len   = proc_ff ? '0 : len_ff;

   always_comb begin
      state_in     = state_ff;
      gain_in      = gain_ff;
      wide_in      = wide_ff;
      len_in       = len_ff;
      rp_in        = rp_ff;
      spikes_in    = spikes_ff;
      proc_in      = proc_ff;
      pos_in       = pos_ff;
      widx_in      = widx_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      dv_in        = dv_ff;
      bit_in       = bit_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      ka_in        = ka_ff;
      kb_in        = kb_ff;
      cnta_in      = cnta_ff;
      cntb_in      = cntb_ff;
      twice_in     = twice_ff;
      prod_in      = prod_ff;
      ok_in        = ok_ff;
      med_in       = med_ff;
      sel_in       = sel_ff;
      val_in       = val_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in    = rsp_kind_ff;
      rsp_cleaned_in = rsp_cleaned_ff;
      rsp_spike_in   = rsp_spike_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_last_in    = rsp_last_ff;
      samp_we      = 1'b0;
      samp_waddr   = widx_ff;
      samp_wdata   = '0;
      samp_raddr   = i_ff[AB-1:0];
      stat_we      = 1'b0;
      stat_raddr   = i_ff[AB-1:0];

      if (csr_we && csr_index == mmd_pkg::CSR_GAIN) begin
         gain_in = csr_wdata;
      end
      if (csr_we && csr_index == mmd_pkg::CSR_WIDE) begin
         wide_in = csr_wdata[0];
      end

      unique case (state_ff)
         mmd_pkg::ST_IDLE: begin
            samp_raddr = rp_ff[AB-1:0];
            if (accept && req_func == mmd_pkg::FUNC_LOAD) begin
               len_in = eff_len;
               if (proc_ff) begin
                  proc_in   = 1'b0;
                  rp_in     = '0;
                  spikes_in = '0;
               end
               if (eff_len < LB'(mmd_pkg::MAX_LEN)) begin
                  samp_we    = 1'b1;
                  samp_waddr = eff_len[AB-1:0];
                  samp_wdata = {1'b0, req_sample};
                  len_in     = eff_len + 1'b1;
               end
               if (req_last_in) begin
                  proc_in   = 1'b1;
                  rp_in     = '0;
                  spikes_in = '0;
                  i_in      = '0;
                  dv_in     = 1'b0;
                  pos_in    = '0;
                  k_in      = '0;
                  if (len_in < LB'(mmd_pkg::NARROW_SPAN)) begin
                     ok_in    = 1'b0;
                     state_in = mmd_pkg::ST_CLEAN;
                  end else begin
                     state_in = mmd_pkg::ST_WIN;
                  end
               end
            end else if (accept && req_func == mmd_pkg::FUNC_READ) begin
               if (proc_ff && rp_ff < len_ff) begin
                  state_in = mmd_pkg::ST_READ;
               end
            end
         end

         mmd_pkg::ST_READ: begin
            rsp_valid_in   = 1'b1;
            rsp_kind_in    = mmd_pkg::KIND_SAMPLE;
            rsp_cleaned_in = samp_rdata_ff[SB-1:0];
            rsp_spike_in   = samp_rdata_ff[SB];
            rsp_count_in   = spikes_ff;
            rsp_last_in    = (rp_ff + 1'b1 == len_ff);
            rp_in          = rp_ff + 1'b1;
            state_in       = mmd_pkg::ST_IDLE;
         end

         // fetch the window, shifting samples in one per cycle
         mmd_pkg::ST_WIN: begin
            samp_raddr = AB'(start_w + LB'(k_ff));
            if (k_ff != '0) begin
               val_in[0] = VB'(signed'(samp_rdata_ff[SB-1:0]));
               for (int j = 1; j < WS; j++) begin
                  val_in[j] = val_ff[j-1];
               end
            end
            if (k_ff == span_w) begin
               k_in     = '0;
               state_in = mmd_pkg::ST_MED;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end

         mmd_pkg::ST_MED, mmd_pkg::ST_MAD: begin
            if (rank == half_w) begin
               sel_in = cand;
            end
            if (k_ff == span_w - 1'b1) begin
               k_in     = '0;
               state_in = (state_ff == mmd_pkg::ST_MED) ? mmd_pkg::ST_DEV
                                                        : mmd_pkg::ST_STORE;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end

         mmd_pkg::ST_DEV: begin
            med_in = sel_ff;
            for (int j = 0; j < WS; j++) begin
               val_in[j] = dif[j][VB] ? VB'(-dif[j]) : VB'(dif[j]);
            end
            state_in = mmd_pkg::ST_MAD;
         end

         mmd_pkg::ST_STORE: begin
            stat_we = 1'b1;
            if ({1'b0, pos_ff} == len_ff - 1'b1) begin
               bit_in   = 4'd15;
               pa_in    = '0;
               pb_in    = '0;
               ka_in    = len_ff[0] ? (len_ff >> 1) : ((len_ff >> 1) - 1'b1);
               kb_in    = len_ff >> 1;
               cnta_in  = '0;
               cntb_in  = '0;
               i_in     = '0;
               dv_in    = 1'b0;
               state_in = mmd_pkg::ST_SEL;
            end else begin
               pos_in   = pos_ff + 1'b1;
               k_in     = '0;
               state_in = mmd_pkg::ST_WIN;
            end
         end

         // one pass per bit, both middle order statistics at once
         mmd_pkg::ST_SEL: begin
            dv_in = i_ff < len_ff;
            i_in  = i_ff + 1'b1;
            if (dv_ff) begin
               if ((mad_rdata_ff & hi_mask) == pa_ff && !mad_rdata_ff[bit_ff]) begin
                  cnta_in = cnta_ff + 1'b1;
               end
               if ((mad_rdata_ff & hi_mask) == pb_ff && !mad_rdata_ff[bit_ff]) begin
                  cntb_in = cntb_ff + 1'b1;
               end
            end
            if (i_ff == len_ff + 1'b1) begin
               if (ka_ff >= cnta_ff) begin
                  pa_in = pa_ff | (SB'(1) << bit_ff);
                  ka_in = ka_ff - cnta_ff;
               end
               if (kb_ff >= cntb_ff) begin
                  pb_in = pb_ff | (SB'(1) << bit_ff);
                  kb_in = kb_ff - cntb_ff;
               end
               i_in    = '0;
               dv_in   = 1'b0;
               cnta_in = '0;
               cntb_in = '0;
               if (bit_ff == 4'd0) begin
                  state_in = mmd_pkg::ST_SUM;
               end else begin
                  bit_in = bit_ff - 1'b1;
               end
            end
         end

         mmd_pkg::ST_SUM: begin
            twice_in = {1'b0, pa_ff} + {1'b0, pb_ff};
            state_in = mmd_pkg::ST_MUL;
         end

         mmd_pkg::ST_MUL: begin
            prod_in  = mmd_pkg::PROD_BITS'(gain_ff) * mmd_pkg::PROD_BITS'(twice_ff);
            ok_in    = twice_ff != '0;
            i_in     = '0;
            dv_in    = 1'b0;
            state_in = mmd_pkg::ST_CLEAN;
         end

         // read-modify-write of every sample, each write lands in the cycle after its read
         mmd_pkg::ST_CLEAN: begin
            dv_in   = i_ff < len_ff;
            widx_in = i_ff[AB-1:0];
            i_in    = i_ff + 1'b1;
            if (dv_ff) begin
               samp_we    = 1'b1;
               samp_waddr = widx_ff;
               samp_wdata = cl_spike ? {1'b1, med_rdata_ff}
                                     : {1'b0, samp_rdata_ff[SB-1:0]};
               if (cl_spike) begin
                  spikes_in = spikes_ff + 1'b1;
               end
            end
            if (i_ff == len_ff + 1'b1) begin
               state_in = mmd_pkg::ST_DONE;
            end
         end

         mmd_pkg::ST_DONE: begin
            rsp_valid_in   = 1'b1;
            rsp_kind_in    = mmd_pkg::KIND_SUMMARY;
            rsp_cleaned_in = '0;
            rsp_spike_in   = 1'b0;
            rsp_count_in   = spikes_ff;
            rsp_last_in    = 1'b0;
            state_in       = mmd_pkg::ST_IDLE;
         end

         default: begin
            state_in = mmd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mmd_pkg::ST_IDLE;
         gain_ff      <= mmd_pkg::GAIN_RESET;
         wide_ff      <= 1'b1;
         len_ff       <= '0;
         rp_ff        <= '0;
         spikes_ff    <= '0;
         proc_ff      <= 1'b0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_ff      <= gain_in;
         wide_ff      <= wide_in;
         len_ff       <= len_in;
         rp_ff        <= rp_in;
         spikes_ff    <= spikes_in;
         proc_ff      <= proc_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      widx_ff        <= widx_in;
      k_ff           <= k_in;
      i_ff           <= i_in;
      bit_ff         <= bit_in;
      pa_ff          <= pa_in;
      pb_ff          <= pb_in;
      ka_ff          <= ka_in;
      kb_ff          <= kb_in;
      cnta_ff        <= cnta_in;
      cntb_ff        <= cntb_in;
      twice_ff       <= twice_in;
      prod_ff        <= prod_in;
      ok_ff          <= ok_in;
      med_ff         <= med_in;
      sel_ff         <= sel_in;
      val_ff         <= val_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_cleaned_ff <= rsp_cleaned_in;
      rsp_spike_ff   <= rsp_spike_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_last_ff    <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (samp_we) begin
         samp_mem[samp_waddr] <= samp_wdata;
      end
      samp_rdata_ff <= samp_mem[samp_raddr];
   end

   always_ff @(posedge clock) begin
      if (stat_we) begin
         med_mem[pos_ff] <= med_ff[SB-1:0];
         mad_mem[pos_ff] <= sel_ff[SB-1:0];
      end
      med_rdata_ff <= med_mem[stat_raddr];
      mad_rdata_ff <= mad_mem[stat_raddr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_cleaned     = rsp_cleaned_ff;
   assign rsp_was_spike   = rsp_spike_ff;
   assign rsp_spike_count = rsp_count_ff;
   assign rsp_last_out    = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_len_max: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LB'(mmd_pkg::MAX_LEN))
      else $error("series length beyond store depth");

   a_rp_bound: assert property (@(posedge clock) disable iff (reset)
      rp_ff <= len_ff)
      else $error("read pointer past series end");

   a_spikes_bound: assert property (@(posedge clock) disable iff (reset)
      spikes_ff <= len_ff)
      else $error("more spikes than samples");

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mmd_pkg::ST_DONE || state_ff == mmd_pkg::ST_READ) |-> !rsp_valid_ff)
      else $error("result register busy when a result is produced");
`endif

endmodule
`default_nettype wire

### tb/mmd_checker.sv
`timescale 1ns / 1ps
module mmd_checker
   import mmd_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire logic                          req_func,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample,
   input  wire logic                          req_last_in,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic                          rsp_kind,
   input  wire logic signed [SAMPLE_BITS-1:0] rsp_cleaned,
   input  wire logic                          rsp_was_spike,
   input  wire logic [LEN_BITS-1:0]           rsp_spike_count,
   input  wire logic                          rsp_last_out,
   input  wire logic                          csr_we,
   input  wire logic [CSR_IDX_BITS-1:0]       csr_index,
   input  wire logic [15:0]                   csr_wdata,
   output int                                 errors,
   output int                                 pending,
   output int                                 results_seen
);

   typedef struct {
      logic                          kind;
      logic signed [SAMPLE_BITS-1:0] cleaned;
      logic                          was_spike;
      logic [LEN_BITS-1:0]           spike_count;
      logic                          last_out;
   } despike_result_type;

   despike_result_type result_q[$];

   logic [15:0] gain;
   logic        wide;
   longint      samples [MAX_LEN];
   longint      medians [MAX_LEN];
   longint      mads    [MAX_LEN];
   bit          marks   [MAX_LEN];
   longint      sort_buf[MAX_LEN];
   int          series_len;
   int          read_ptr;
   int          spikes;
   bit          closed;
   int          err_count;

   task automatic sort_prefix(input int n);
      int     i;
      int     j;
      longint t;
      for (i = 1; i < n; i++) begin
         t = sort_buf[i];
         j = i;
         while (j > 0 && sort_buf[j-1] > t) begin
            sort_buf[j] = sort_buf[j-1];
            j--;
         end
         sort_buf[j] = t;
      end
   endtask

   // median / MAD per position, then median of MADs, then spike replacement
   task automatic despike_series();
      int     i;
      int     k;
      int     span;
      int     half;
      int     start;
      longint med;
      longint d;
      longint twice_m;
      spikes = 0;
      for (i = 0; i < series_len; i++) marks[i] = 0;
      if (series_len < NARROW_SPAN) return;
      span = (wide && series_len >= WIDE_SPAN) ? WIDE_SPAN : NARROW_SPAN;
      half = span / 2;
      for (i = 0; i < series_len; i++) begin
         if (i < half) start = 0;
         else if (i - half + span > series_len) start = series_len - span;
         else start = i - half;
         for (k = 0; k < span; k++) sort_buf[k] = samples[start+k];
         sort_prefix(span);
         med = sort_buf[half];
         for (k = 0; k < span; k++) begin
            d = samples[start+k] - med;
            sort_buf[k] = (d < 0) ? -d : d;
         end
         sort_prefix(span);
         medians[i] = med;
         mads[i]    = sort_buf[half];
      end
      for (i = 0; i < series_len; i++) sort_buf[i] = mads[i];
      sort_prefix(series_len);
      if (series_len % 2) twice_m = 2 * sort_buf[series_len/2];
      else twice_m = sort_buf[series_len/2-1] + sort_buf[series_len/2];
      if (twice_m == 0) return;
      for (i = 0; i < series_len; i++) begin
         d = samples[i] - medians[i];
         if (d < 0) d = -d;
         if (d * 512 > longint'(gain) * twice_m) begin
            samples[i] = medians[i];
            marks[i]   = 1;
            spikes++;
         end
      end
   endtask

   task automatic report_mismatch(input string field, input longint got, input longint want);
      err_count++;
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
   endtask

   always @(posedge clock) begin
      despike_result_type want;
      if (reset) begin
         gain       = GAIN_RESET;
         wide       = 1'b1;
         series_len = 0;
         read_ptr   = 0;
         spikes     = 0;
         closed     = 0;
         result_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_GAIN) gain = csr_wdata;
            else if (csr_index == CSR_WIDE) wide = csr_wdata[0];
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen <= results_seen + 1;
            if (result_q.size() == 0) begin
               report_mismatch("unexpected transaction", 1, 0);
            end else begin
               want = result_q.pop_front();
               if (rsp_kind !== want.kind) report_mismatch("kind", rsp_kind, want.kind);
               if (rsp_cleaned !== want.cleaned)
                  report_mismatch("cleaned", rsp_cleaned, want.cleaned);
               if (rsp_was_spike !== want.was_spike)
                  report_mismatch("was_spike", rsp_was_spike, want.was_spike);
               if (rsp_spike_count !== want.spike_count)
                  report_mismatch("spike_count", rsp_spike_count, want.spike_count);
               if (rsp_last_out !== want.last_out)
                  report_mismatch("last_out", rsp_last_out, want.last_out);
            end
         end
         if (req_valid && !req_stall) begin
            if (req_func == FUNC_LOAD) begin
               if (closed) begin
                  closed     = 0;
                  series_len = 0;
                  read_ptr   = 0;
                  spikes     = 0;
               end
               if (series_len < MAX_LEN) begin
                  samples[series_len] = longint'(req_sample);
                  series_len++;
               end
               if (req_last_in) begin
                  despike_series();
                  closed   = 1;
                  read_ptr = 0;
                  want.kind        = KIND_SUMMARY;
                  want.cleaned     = '0;
                  want.was_spike   = 1'b0;
                  want.spike_count = spikes[LEN_BITS-1:0];
                  want.last_out    = 1'b0;
                  result_q.push_back(want);
               end
            end else if (closed && read_ptr < series_len) begin
               want.kind        = KIND_SAMPLE;
               want.cleaned     = samples[read_ptr][SAMPLE_BITS-1:0];
               want.was_spike   = marks[read_ptr];
               want.spike_count = spikes[LEN_BITS-1:0];
               want.last_out    = (read_ptr + 1 == series_len);
               result_q.push_back(want);
               read_ptr++;
            end
         end
      end
      pending <= result_q.size();
      errors  <= err_count;
   end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import mmd_pkg::*;

   localparam int  ITEM_TARGET = 1900;
   localparam int  CYCLE_LIMIT = 4_000_000;    // watchdog on total simulated cycles
   localparam int  SETTLE      = 12;           // readout latency plus margin
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE = 2'd2;   // unmapped, must be ignored

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic                          req_func;
   logic signed [SAMPLE_BITS-1:0] req_sample;
   logic                          req_last_in;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic                          rsp_kind;
   logic signed [SAMPLE_BITS-1:0] rsp_cleaned;
   logic                          rsp_was_spike;
   logic [LEN_BITS-1:0]           rsp_spike_count;
   logic                          rsp_last_out;
   logic                          csr_we;
   logic [CSR_IDX_BITS-1:0]       csr_index;
   logic [15:0]                   csr_wdata;

   int errors;
   int pending;
   int results_seen;
   int cycles;
   int mode;          // 0 none, 1 sender idles, 2 receiver stalls, 3 both lightly
   int items;
   int series_done;
   int longest;

   median_mad_despiker u_top (.*);

   mmd_checker u_checker (.*);

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // receiver back-pressure follows the current idling phase
   always @(posedge clock) begin
      rsp_stall <= (mode == 2 && $urandom_range(99) < 59) ||
                   (mode == 3 && $urandom_range(99) < 7);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // one transaction on the request channel, held until accepted
   task automatic put(input logic f, input logic [15:0] s, input logic l);
      while ((mode == 1 && $urandom_range(99) < 59) ||
             (mode == 3 && $urandom_range(99) < 7)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_func    <= f;
      req_sample  <= s;
      req_last_in <= l;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // sender holds off until every expected result is back, then lets the block settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx, input logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // shape: 0 full random, 1 ramp with noise and spikes, 2 flat, 3 quiet with rail spikes
   function automatic logic [15:0] series_value(input int shape, input int base,
                                                 input int slope, input int i);
      int v;
      case (shape)
         0: v = $urandom;
         1: begin
            v = base + slope * i + $urandom_range(6) - 3;
            if ($urandom_range(99) < 5) v = v + $urandom_range(20000) - 10000;
         end
         2: v = base;
         default: begin
            v = $urandom_range(4) - 2;
            if ($urandom_range(99) < 6) v = $urandom_range(1) ? 32767 : -32768;
         end
      endcase
      return v[15:0];
   endfunction

   // loads len samples, then issues n_reads readouts; stray reads sprinkled in as noise
   task automatic run_series(input int len, input int shape, input int n_reads);
      int i;
      int base;
      int slope;
      base  = $urandom_range(40000) - 20000;
      slope = $urandom_range(8) - 4;
      for (i = 0; i < len; i++) begin
         if ($urandom_range(99) < 2) put(FUNC_READ, 16'($urandom), 1'($urandom_range(1)));
         put(FUNC_LOAD, series_value(shape, base, slope, i), i == len - 1);
      end
      for (i = 0; i < n_reads; i++) put(FUNC_READ, 16'($urandom), 1'($urandom_range(1)));
      items += len + ((n_reads < len) ? n_reads : len);
      series_done++;
      if (len > longest) longest = len;
   endtask

   task automatic run_fixed(input logic [15:0] vals[$], input int n_reads);
      int i;
      for (i = 0; i < vals.size(); i++) put(FUNC_LOAD, vals[i], i == vals.size() - 1);
      for (i = 0; i < n_reads; i++) put(FUNC_READ, 16'h0000, 1'(i % 2));
      items += vals.size() + n_reads;
      series_done++;
   endtask

   initial begin
      int len;
      int pick;
      logic [15:0] gval;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_func    <= FUNC_LOAD;
      req_sample  <= '0;
      req_last_in <= 1'b0;
      csr_we      <= 1'b0;
      csr_index   <= '0;
      csr_wdata   <= '0;
      mode        = 0;
      items       = 0;
      series_done = 0;
      longest     = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // readouts before any series exist: no response
      put(FUNC_READ, 16'hffff, 1'b1);
      put(FUNC_READ, 16'h0000, 1'b0);
      // minimal full window with both rails, one readout past the end
      run_fixed('{16'd0, 16'd1, 16'hffff, 16'd2, 16'h7fff, 16'hfffe, 16'd1, 16'd0,
                  16'h8000}, 10);
      drain();
      write_csr(CSR_WIDE, 16'd0);
      write_csr(CSR_GAIN, 16'd0);
      // short series passes through untouched
      run_fixed('{16'd5, 16'h8000, 16'h7fff}, 4);
      drain();
      write_csr(CSR_GAIN, 16'hffff);
      // flat series: zero median of MADs
      longest = 9;
      run_series(12, 2, 12);
      drain();
      write_csr(CSR_GAIN, GAIN_RESET);
      write_csr(CSR_WIDE, 16'd1);

      while (items < ITEM_TARGET) begin
         mode = (series_done / 3) % 4;
         if ($urandom_range(99) < 35) begin
            drain();
            pick = $urandom_range(5);
            case (pick)
               0: gval = 16'd0;
               1: gval = 16'hffff;
               2: gval = 16'($urandom);
               default: gval = 16'($urandom_range(2500, 300));
            endcase
            write_csr(CSR_GAIN, gval);
            write_csr(CSR_WIDE, 16'($urandom));
            if ($urandom_range(99) < 20)
               write_csr(CSR_SPARE | CSR_IDX_BITS'($urandom_range(1)), 16'($urandom));
         end
         if (series_done == 10) begin
            // overflow: extra samples dropped, readout cut short by the next series
            drain();
            write_csr(CSR_WIDE, 16'd1);
            run_series(MAX_LEN + 6, 1, 30);
            continue;
         end
         pick = $urandom_range(99);
         if (pick < 10) len = $urandom_range(8, 1);
         else if (pick < 70) len = $urandom_range(40, 9);
         else len = $urandom_range(90, 24);
         pick = $urandom_range(99);
         run_series(len, (pick < 55) ? 1 : (pick < 70) ? 3 : (pick < 85) ? 0 : 2,
                    ($urandom_range(99) < 15) ? $urandom_range(len) : len + $urandom_range(2));
      end

      mode = 0;
      drain();
      $display("Ran %0d series (longest %0d samples), %0d counted transactions,",
               series_done, longest, items);
      $display("%0d responses checked across both window widths and gain extremes.",
               results_seen);
      if (errors == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### sim.f
rtl/mmd_pkg.sv
rtl/median_mad_despiker.sv
tb/mmd_checker.sv
tb/testbench.sv
